@@ rtl/i2cms_pkg.sv @@
// shared types and constants for the i2c master bit sequencer
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int unsigned QDEPTH = 2;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_SEND     = 3'd2,
        OP_RECV     = 3'd3,
        OP_SEND_ACK = 3'd4,
        OP_RECV_ACK = 3'd5
    } t_op;

    // command word passed from the front to the back
    typedef struct packed {
        t_op        op;
        logic [7:0] data;   // tx byte for send, line bits otherwise
        logic       ack;
    } t_cmd;

endpackage

@@ rtl/i2cms_front.sv @@
// command intake: filters unused opcodes and queues commands for the sequencer
`timescale 1ns / 1ps

module i2cms_front import i2cms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_out,
    input  logic [7:0] i_line_bits,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    t_cmd                  r_mem [QDEPTH];
    logic                  r_wr_ptr, n_wr_ptr;
    logic                  r_rd_ptr, n_rd_ptr;
    logic [1:0]            r_count, n_count;
    logic                  s_known;
    logic                  s_push;
    logic                  s_pop;
    t_cmd                  s_cmd;

    always_comb begin
        s_known    = 1'b1;
        s_cmd.op   = OP_START;
        unique case (i_opcode)
            OP_START:    s_cmd.op = OP_START;
            OP_STOP:     s_cmd.op = OP_STOP;
            OP_SEND:     s_cmd.op = OP_SEND;
            OP_RECV:     s_cmd.op = OP_RECV;
            OP_SEND_ACK: s_cmd.op = OP_SEND_ACK;
            OP_RECV_ACK: s_cmd.op = OP_RECV_ACK;
            default:     s_known  = 1'b0;
        endcase
        s_cmd.data = (i_opcode == OP_SEND) ? i_tx_byte : i_line_bits;
        s_cmd.ack  = i_ack_out;
    end

    assign o_in_stall  = (r_count == 2'(QDEPTH));
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];

    assign s_push = i_in_valid && !o_in_stall && s_known;
    assign s_pop  = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = s_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = s_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, s_push} - {1'b0, s_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= s_cmd;
        end
    end

endmodule

@@ rtl/i2cms_back.sv @@
// pin step sequencer with output register
`timescale 1ns / 1ps

module i2cms_back import i2cms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_drive,
    output logic       o_sda_drive,
    output logic       o_sample_step,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_in,
    output logic       o_last
);

    logic       r_busy, n_busy;
    t_cmd       r_cmd, n_cmd;
    logic [1:0] r_phase, n_phase;
    logic [2:0] r_bit, n_bit;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_out_valid, n_out_valid;
    logic       r_sample, r_last, r_ack_in;
    logic [7:0] r_rx_byte;

    logic       s_adv;
    logic       s_scl, s_sda, s_sample, s_last;
    logic [7:0] s_rx;
    logic       s_ack;

    assign s_adv = r_busy && (!r_out_valid || !i_out_stall);

    // step decode
    always_comb begin
        s_scl    = r_scl;
        s_sda    = r_sda;
        s_sample = 1'b0;
        s_last   = 1'b0;
        s_rx     = 8'd0;
        s_ack    = 1'b0;
        unique case (r_cmd.op)
            OP_START: begin
                unique case (r_phase)
                    2'd0:    s_sda = 1'b1;
                    2'd1:    s_scl = 1'b1;
                    2'd2:    s_sda = 1'b0;
                    default: begin
                        s_scl  = 1'b0;
                        s_last = 1'b1;
                    end
                endcase
            end
            OP_STOP: begin
                unique case (r_phase)
                    2'd0:    s_sda = 1'b0;
                    2'd1:    s_scl = 1'b1;
                    default: begin
                        s_sda  = 1'b1;
                        s_last = 1'b1;
                    end
                endcase
            end
            OP_SEND: begin
                unique case (r_phase)
                    2'd0:    s_sda = r_cmd.data[7];
                    2'd1:    s_scl = 1'b1;
                    default: begin
                        s_scl  = 1'b0;
                        s_last = (r_bit == 3'd7);
                    end
                endcase
            end
            OP_RECV: begin
                unique case (r_phase)
                    2'd0:    s_sda = 1'b1;
                    2'd1:    s_scl = 1'b1;
                    2'd2:    s_sample = 1'b1;
                    default: begin
                        s_scl  = 1'b0;
                        s_last = (r_bit == 3'd7);
                        s_rx   = s_last ? r_cmd.data : 8'd0;
                    end
                endcase
            end
            OP_SEND_ACK: begin
                unique case (r_phase)
                    2'd0:    s_sda = r_cmd.ack;
                    2'd1:    s_scl = 1'b1;
                    default: begin
                        s_scl  = 1'b0;
                        s_last = 1'b1;
                    end
                endcase
            end
            OP_RECV_ACK: begin
                unique case (r_phase)
                    2'd0:    s_sda = 1'b1;
                    2'd1:    s_scl = 1'b1;
                    2'd2:    s_sample = 1'b1;
                    default: begin
                        s_scl  = 1'b0;
                        s_last = 1'b1;
                        s_ack  = r_cmd.data[7];
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign o_cmd_pop = i_cmd_valid && (!r_busy || (s_adv && s_last));

    // sequencer next state
    always_comb begin
        n_busy  = r_busy;
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_scl   = r_scl;
        n_sda   = r_sda;
        if (s_adv) begin
            n_scl   = s_scl;
            n_sda   = s_sda;
            n_phase = r_phase + 2'd1;
            if (s_last) begin
                n_busy = 1'b0;
            end else if (r_cmd.op == OP_SEND && r_phase == 2'd2) begin
                n_phase    = 2'd0;
                n_bit      = r_bit + 3'd1;
                n_cmd.data = {r_cmd.data[6:0], 1'b0};
            end else if (r_cmd.op == OP_RECV && r_phase == 2'd3) begin
                n_phase = 2'd1;
                n_bit   = r_bit + 3'd1;
            end
        end
        if (o_cmd_pop) begin
            n_busy  = 1'b1;
            n_cmd   = i_cmd;
            n_phase = 2'd0;
            n_bit   = 3'd0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= 2'd0;
            r_bit       <= 3'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (s_adv) begin
            r_sample  <= s_sample;
            r_last    <= s_last;
            r_rx_byte <= s_rx;
            r_ack_in  <= s_ack;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_drive   = r_scl;
    assign o_sda_drive   = r_sda;
    assign o_sample_step = r_sample;
    assign o_rx_byte     = r_rx_byte;
    assign o_ack_in      = r_ack_in;
    assign o_last        = r_last;

endmodule

@@ rtl/i2c_master_bit_sequencer.sv @@
// top level of the i2c master bit sequencer
// the first step word of a command is registered after the command register takes it
// throughput: one step word per cycle from the single step sequencer when not stalled;
// a command gives 3 to 25 step words by opcode; a 2-entry command queue hides intake
// unused opcodes are dropped at intake and produce no words
// reset: synchronous, active low; scl and sda levels return to released, queue empties
`timescale 1ns / 1ps

module i2c_master_bit_sequencer import i2cms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_out,
    input  logic [7:0] i_line_bits,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_drive,
    output logic       o_sda_drive,
    output logic       o_sample_step,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_in,
    output logic       o_last
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    i2cms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_tx_byte   (i_tx_byte),
        .i_ack_out   (i_ack_out),
        .i_line_bits (i_line_bits),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    i2cms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_scl_drive   (o_scl_drive),
        .o_sda_drive   (o_sda_drive),
        .o_sample_step (o_sample_step),
        .o_rx_byte     (o_rx_byte),
        .o_ack_in      (o_ack_in),
        .o_last        (o_last)
    );

endmodule
